### hw/rtl/ltsg_pkg.sv
// types and constants shared by the link timeout and sequence guard unit
// no dependencies; imported by every module of the block
package ltsg_pkg;

  typedef enum logic [1:0] {
    FuncFrame  = 2'd0,
    FuncQuery  = 2'd1,
    FuncAccept = 2'd2,
    FuncReset  = 2'd3
  } func_e;

  // configuration register indexes
  localparam logic [0:0] CfgTimeout = 1'b0;
  localparam logic [0:0] CfgMask    = 1'b1;

  localparam logic [31:0] TimeoutReset = 32'd1000;
  localparam logic [7:0]  MaskReset    = 8'hFF;

  // one registered command as seen by the work stage
  typedef struct packed {
    logic        valid;
    func_e       func;
    logic [31:0] now_time;
    logic [7:0]  tool_index;
    logic [7:0]  sequence_req;
  } cmd_t;

endpackage

### hw/rtl/link_timeout_and_sequence_guard_unit.sv
// top level of the link timeout and sequence guard unit
// depends on ltsg_pkg, ltsg_link_watch and ltsg_seq_guard
//
// One command is taken per clock whenever start_i is high; busy_o never rises.
// A command is registered on entry, evaluated against the state in the
// following cycle, and its result appears on link_lost_o and accepted_o with
// done_o high for exactly one cycle from the result register. State written
// by one command is seen by the very next one. The receiver cannot stall the
// result strobe, so it must take each result in its strobe cycle.
// Configuration writes take effect at the write edge and are meant to be made
// while no command is in flight.
module link_timeout_and_sequence_guard_unit #(
  parameter int unsigned TOOL_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_time_i,
  input  logic [7:0]  tool_index_i,
  input  logic [7:0]  sequence_req_i,
  output logic        done_o,
  output logic        link_lost_o,
  output logic        accepted_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ltsg_pkg::*;

  cmd_t        cmd_q;
  logic        cmd_valid_q;
  logic [31:0] timeout_q;
  logic [7:0]  mask_q;
  logic        lost_d, acc_d;
  logic        done_q, lost_q, acc_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      mask_q    <= MaskReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTimeout: timeout_q <= cfg_data_i;
        CfgMask:    mask_q    <= cfg_data_i[7:0];
        default:    ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= start_i && !busy_o;
    end
  end

  // payload only; qualified by cmd_valid_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q.valid        <= 1'b1;
      cmd_q.func         <= func_e'(func_i);
      cmd_q.now_time     <= now_time_i;
      cmd_q.tool_index   <= tool_index_i;
      cmd_q.sequence_req <= sequence_req_i;
    end
  end

  cmd_t cmd_stage;
  always_comb begin
    cmd_stage       = cmd_q;
    cmd_stage.valid = cmd_valid_q;
  end

  ltsg_link_watch u_link_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_stage),
    .timeout_ms_i (timeout_q),
    .link_lost_o  (lost_d)
  );

  ltsg_seq_guard #(
    .TOOL_SLOTS (TOOL_SLOTS)
  ) u_seq_guard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_stage),
    .present_mask_i (mask_q),
    .accepted_o     (acc_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      lost_q <= 1'b0;
      acc_q  <= 1'b0;
    end else begin
      done_q <= cmd_valid_q;
      lost_q <= lost_d;
      acc_q  <= acc_d;
    end
  end

  assign done_o      = done_q;
  assign link_lost_o = lost_q;
  assign accepted_o  = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("beat taken without a result two cycles later");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_lost_o || accepted_o) |-> done_o)
    else $error("result flag outside the strobe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(link_lost_o && accepted_o))
    else $error("both result flags set");

endmodule

### hw/rtl/ltsg_link_watch.sv
// link-loss watchdog: last frame time, frame-seen flag and the timeout compare
// depends on ltsg_pkg
module ltsg_link_watch (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ltsg_pkg::cmd_t cmd_i,
  input  logic [31:0]    timeout_ms_i,
  output logic           link_lost_o
);
  import ltsg_pkg::*;

  logic [31:0] last_time_q, last_time_d;
  logic        seen_q, seen_d;
  logic [31:0] elapsed;
  logic        frame_hit;

  assign frame_hit = cmd_i.valid && (cmd_i.func == FuncFrame);

  always_comb begin
    last_time_d = last_time_q;
    seen_d      = seen_q;
    if (frame_hit) begin
      last_time_d = cmd_i.now_time;
      seen_d      = 1'b1;
    end
  end

  // wrapping difference, modulo 2^32
  assign elapsed = cmd_i.now_time - last_time_q;

  assign link_lost_o = cmd_i.valid && (cmd_i.func == FuncQuery) &&
                       (!seen_q || (elapsed >= timeout_ms_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      seen_q      <= 1'b0;
    end else begin
      last_time_q <= last_time_d;
      seen_q      <= seen_d;
    end
  end

  // once a frame is seen, only reset can clear the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("frame seen flag dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_hit |=> (seen_q && last_time_q == $past(cmd_i.now_time)))
    else $error("frame time not captured");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.func == FuncQuery && !seen_q) |-> link_lost_o)
    else $error("query before any frame must report loss");

endmodule

### hw/rtl/ltsg_seq_guard.sv
// per-tool replay guard: stored sequence and valid mark for each slot
// depends on ltsg_pkg
module ltsg_seq_guard #(
  parameter int unsigned TOOL_SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ltsg_pkg::cmd_t cmd_i,
  input  logic [7:0]     present_mask_i,
  output logic           accepted_o
);
  import ltsg_pkg::*;

  logic [7:0]            last_seq_q [TOOL_SLOTS];
  logic [TOOL_SLOTS-1:0] seq_valid_q, seq_valid_d;
  logic [TOOL_SLOTS-1:0] slot_hit;
  logic [7:0]            stored_seq;
  logic                  stored_valid;
  logic                  present;
  logic [7:0]            diff;
  logic                  fresh;
  logic                  is_accept;
  logic                  is_reset;

  assign is_accept = cmd_i.valid && (cmd_i.func == FuncAccept);
  assign is_reset  = cmd_i.valid && (cmd_i.func == FuncReset);

  // slot decode; an out-of-range tool hits no slot
  always_comb begin
    stored_seq   = '0;
    stored_valid = 1'b0;
    present      = 1'b0;
    for (int i = 0; i < TOOL_SLOTS; i++) begin
      slot_hit[i] = (cmd_i.tool_index == 8'(i));
      if (slot_hit[i]) begin
        stored_seq   = last_seq_q[i];
        stored_valid = seq_valid_q[i];
        present      = present_mask_i[i];
      end
    end
  end

  // ahead on the 8-bit ring by 1..127
  assign diff  = cmd_i.sequence_req - stored_seq;
  assign fresh = !stored_valid || ((diff != 8'd0) && !diff[7]);

  assign accepted_o = is_accept && present && fresh;

  always_comb begin
    seq_valid_d = seq_valid_q;
    if (is_reset) begin
      seq_valid_d = '0;
    end else if (accepted_o) begin
      seq_valid_d = seq_valid_q | slot_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= '0;
    end else begin
      seq_valid_q <= seq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TOOL_SLOTS; i++) begin
      if (accepted_o && slot_hit[i]) begin
        last_seq_q[i] <= cmd_i.sequence_req;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_reset |=> (seq_valid_q == '0))
    else $error("reset beat left a slot valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted_o |=> (seq_valid_q != '0))
    else $error("accepted beat did not mark its slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tool_index >= 8'(TOOL_SLOTS)) |-> !accepted_o)
    else $error("out-of-range tool accepted");

endmodule
